FILE: sv/itt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_pkg: shared definitions of the interval task timer table
// Sizes of the slot table, field widths, command codes and register map.
// ----------------------------------------------------------------------------
package itt_pkg;

	localparam int SLOTS    = 8;
	localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int TICK_W   = 32;
	localparam int PERIOD_W = 32;
	localparam int TPM_W    = 16;
	localparam int NEED_W   = PERIOD_W + TPM_W;
	localparam int TIDX_W   = 3;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 3;

	localparam logic [PADDR_W-3:0] REG_TICKS_PER_MS = '0;
	localparam logic [TPM_W-1:0]   TPM_RESET        = 16'd1;

	localparam logic CMD_CREATE = 1'b0;
	localparam logic CMD_UPDATE = 1'b1;

	function automatic logic [TIDX_W-1:0] to_task_index(input logic [IDX_W-1:0] idx);
		logic [IDX_W+TIDX_W-1:0] wide;
		wide = {{TIDX_W{1'b0}}, idx};
		return wide[TIDX_W-1:0];
	endfunction

endpackage

FILE: sv/itt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_item_if / itt_result_if: valid-ready channels of the timer table
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface itt_item_if import itt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [TICK_W-1:0]   now_ticks;
	logic [PERIOD_W-1:0] period_ms;
	logic                periodic;

	modport source (output valid, cmd, now_ticks, period_ms, periodic, input ready);
	modport sink   (input valid, cmd, now_ticks, period_ms, periodic, output ready);
endinterface

interface itt_result_if import itt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIDX_W-1:0] task_index;
	logic              accepted;
	logic              fired;
	logic              last;

	modport source (output valid, task_index, accepted, fired, last, input ready);
	modport sink   (input valid, task_index, accepted, fired, last, output ready);
endinterface

FILE: sv/itt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/interval_task_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_task_timer_table: table of interval timers with a shared compare
// Create beats claim the next free slot, or are refused when all are taken;
// update beats scan the slots and report every slot that has reached its period.
// ----------------------------------------------------------------------------
// Create: the item goes to the response state, which registers the result beat
// once the output is free; the next item is taken only after that.
// Update: the slot scan reads each slot in turn through one read port and one
// shared 32x16 multiplier; results then follow at one slot per cycle while the
// output is not stalled, up to the highest fired slot, or one beat if none fired.
// Reset clears the active bits, the slot count and sets ticks_per_ms to 1.
// No clearing pass is needed; slot storage is only read after it is written.
// ----------------------------------------------------------------------------
module interval_task_timer_table import itt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	itt_item_if.sink           item,
	itt_result_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT,
		ST_RESP
	} state_t;

	state_t              state_q;
	logic [TPM_W-1:0]    tpm_q;
	logic [CNT_W-1:0]    count_q;
	logic [TICK_W-1:0]   now_q;
	logic [SLOTS-1:0]    active_q;
	logic [SLOTS-1:0]    fire_q;
	logic [CNT_W-1:0]    fire_cnt_q;
	logic [CNT_W-1:0]    rd_cnt_q;
	logic [CNT_W-1:0]    em_cnt_q;
	logic [IDX_W-1:0]    resp_idx_q;
	logic                resp_acc_q;

	logic                v_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                v_s2;
	logic [IDX_W-1:0]    idx_s2;
	logic [NEED_W-1:0]   need_s2;
	logic [TICK_W-1:0]   elapsed_s2;
	logic                periodic_s2;

	logic                out_valid_q;
	logic [TIDX_W-1:0]   out_index_q;
	logic                out_acc_q;
	logic                out_fired_q;
	logic                out_last_q;

	logic                accept;
	logic                is_create;
	logic                create_ok;
	logic [IDX_W-1:0]    slot_new;
	logic                rd_go;
	logic [IDX_W-1:0]    raddr;
	logic [TICK_W-1:0]   rd_start;
	logic [PERIOD_W:0]   rd_param;
	logic [NEED_W-1:0]   product;
	logic                hit;
	logic                scan_done;
	logic                out_free;
	logic [IDX_W-1:0]    em_idx;
	logic                em_bit;
	logic                start_we;
	logic [IDX_W-1:0]    start_waddr;
	logic [TICK_W-1:0]   start_wdata;
	logic                param_we;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && paddr[PADDR_W-1:2] == REG_TICKS_PER_MS;
	assign prdata = (paddr[PADDR_W-1:2] == REG_TICKS_PER_MS) ?
		{{(DATA_W-TPM_W){1'b0}}, tpm_q} : '0;

	assign item.ready = state_q == ST_IDLE;
	assign accept     = item.valid && item.ready;
	assign is_create  = item.cmd == CMD_CREATE;
	assign create_ok  = count_q < CNT_W'(SLOTS);
	assign slot_new   = count_q[IDX_W-1:0];

	assign rd_go   = state_q == ST_SCAN && rd_cnt_q < count_q;
	assign raddr   = rd_cnt_q[IDX_W-1:0];
	assign product = rd_param[PERIOD_W-1:0] * tpm_q;
	assign hit     = v_s2 && active_q[idx_s2] &&
		{{TPM_W{1'b0}}, elapsed_s2} >= need_s2;
	assign scan_done = state_q == ST_SCAN && !rd_go && !v_s1 && !v_s2;

	assign out_free = !out_valid_q || result.ready;
	assign em_idx   = em_cnt_q[IDX_W-1:0];
	assign em_bit   = fire_q[em_idx];

	assign param_we = accept && is_create && create_ok;

	always_comb begin
		if (hit && periodic_s2) begin
			start_we    = 1'b1;
			start_waddr = idx_s2;
			start_wdata = now_q;
		end else begin
			start_we    = param_we;
			start_waddr = slot_new;
			start_wdata = item.now_ticks;
		end
	end

	itt_ram #(
		.WIDTH(TICK_W),
		.DEPTH(SLOTS)
	) u_start_ram (
		.clk  (clk),
		.we   (start_we),
		.waddr(start_waddr),
		.wdata(start_wdata),
		.raddr(raddr),
		.rdata(rd_start)
	);

	itt_ram #(
		.WIDTH(PERIOD_W + 1),
		.DEPTH(SLOTS)
	) u_param_ram (
		.clk  (clk),
		.we   (param_we),
		.waddr(slot_new),
		.wdata({item.periodic, item.period_ms}),
		.raddr(raddr),
		.rdata(rd_param)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tpm_q       <= TPM_RESET;
			count_q     <= '0;
			now_q       <= '0;
			active_q    <= '0;
			fire_q      <= '0;
			fire_cnt_q  <= '0;
			rd_cnt_q    <= '0;
			em_cnt_q    <= '0;
			resp_idx_q  <= '0;
			resp_acc_q  <= 1'b0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			v_s2        <= 1'b0;
			idx_s2      <= '0;
			need_s2     <= '0;
			elapsed_s2  <= '0;
			periodic_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_acc_q   <= 1'b0;
			out_fired_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				tpm_q <= pwdata[TPM_W-1:0];
			end
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end

			v_s1        <= rd_go;
			idx_s1      <= raddr;
			v_s2        <= v_s1;
			idx_s2      <= idx_s1;
			need_s2     <= product;
			elapsed_s2  <= now_q - rd_start;
			periodic_s2 <= rd_param[PERIOD_W];

			if (hit) begin
				fire_q[idx_s2] <= 1'b1;
				fire_cnt_q     <= fire_cnt_q + 1'b1;
				if (!periodic_s2) begin
					active_q[idx_s2] <= 1'b0;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q <= item.now_ticks;
						if (is_create) begin
							if (create_ok) begin
								active_q[slot_new] <= 1'b1;
								count_q            <= count_q + 1'b1;
								resp_idx_q         <= slot_new;
								resp_acc_q         <= 1'b1;
							end else begin
								resp_idx_q <= '0;
								resp_acc_q <= 1'b0;
							end
							state_q <= ST_RESP;
						end else begin
							rd_cnt_q   <= '0;
							fire_q     <= '0;
							fire_cnt_q <= '0;
							state_q    <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_go) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (scan_done) begin
						if (fire_cnt_q == '0) begin
							resp_idx_q <= '0;
							resp_acc_q <= 1'b0;
							state_q    <= ST_RESP;
						end else begin
							em_cnt_q <= '0;
							state_q  <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (!em_bit) begin
						em_cnt_q <= em_cnt_q + 1'b1;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_index_q <= to_task_index(em_idx);
						out_acc_q   <= 1'b0;
						out_fired_q <= 1'b1;
						out_last_q  <= fire_cnt_q == CNT_W'(1);
						fire_cnt_q  <= fire_cnt_q - 1'b1;
						em_cnt_q    <= em_cnt_q + 1'b1;
						if (fire_cnt_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_index_q <= to_task_index(resp_idx_q);
						out_acc_q   <= resp_acc_q;
						out_fired_q <= 1'b0;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid      = out_valid_q;
	assign result.task_index = out_index_q;
	assign result.accepted   = out_acc_q;
	assign result.fired      = out_fired_q;
	assign result.last       = out_last_q;

endmodule

FILE: sv/itt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_checker: port-level checks of the interval task timer table
// Watches the item, result and register ports over time.
// ----------------------------------------------------------------------------
module itt_checker import itt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input logic [TIDX_W-1:0] result_task_index,
	input logic              result_accepted,
	input logic              result_fired,
	input logic              result_last,
	input logic              pready
);

	// A stalled result beat keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid &&
		$stable(result_task_index) && $stable(result_accepted) &&
		$stable(result_fired) && $stable(result_last))
		else $error("result beat changed while stalled");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while previous item in progress");

	// A beat is never both a create answer and a firing.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result_accepted && result_fired))
		else $error("result both accepted and fired");

	// An accepted create answer is always the only beat of its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_accepted |-> result_last)
		else $error("create result without last");

	// The register port never inserts wait states.
	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind interval_task_timer_table itt_checker u_itt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.result_task_index(result.task_index),
	.result_accepted  (result.accepted),
	.result_fired     (result.fired),
	.result_last      (result.last),
	.pready           (pready)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the interval task timer table
// Builds the slot table with directed creates, then runs random update scans
// and creates over a moving tick count under several tick rates and handshake
// patterns. A scoreboard predicts every result beat and checks it in order.
// ----------------------------------------------------------------------------
module tb_top;
	import itt_pkg::*;

	localparam int RUN_LIMIT     = 400_000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = SLOTS + 8;
	localparam int PHASE_ITEMS   = 56;

	typedef struct packed {
		logic                cmd;
		logic [TICK_W-1:0]   now_ticks;
		logic [PERIOD_W-1:0] period_ms;
		logic                periodic;
	} timer_item_t;

	typedef struct packed {
		logic [TIDX_W-1:0] task_index;
		logic              accepted;
		logic              fired;
		logic              last;
	} timer_result_t;

	class timer_slot_book;
		bit [TICK_W-1:0]   slot_start[SLOTS];
		bit [PERIOD_W-1:0] slot_period[SLOTS];
		bit                slot_active[SLOTS];
		bit                slot_periodic[SLOTS];
		int unsigned       slot_count;
		bit [TPM_W-1:0]    ticks_per_ms;
		timer_result_t     due_results[$];
		int unsigned       mismatches;
		int unsigned       items_seen;
		int unsigned       updates_seen;
		int unsigned       fires_seen;
		int unsigned       refusals_seen;

		function new();
			ticks_per_ms = TPM_RESET;
			slot_count = 0;
			foreach (slot_active[i])
				slot_active[i] = 1'b0;
		endfunction

		function void note_item(timer_item_t it);
			timer_result_t   r;
			bit [TICK_W-1:0] elapsed;
			bit [NEED_W-1:0] need;
			int              fired_now;
			fired_now = 0;
			items_seen++;
			if (it.cmd == CMD_CREATE) begin
				r = '0;
				r.last = 1'b1;
				if (slot_count < SLOTS) begin
					slot_start[slot_count]    = it.now_ticks;
					slot_period[slot_count]   = it.period_ms;
					slot_periodic[slot_count] = it.periodic;
					slot_active[slot_count]   = 1'b1;
					r.task_index = TIDX_W'(slot_count);
					r.accepted   = 1'b1;
					slot_count++;
				end else begin
					refusals_seen++;
				end
				due_results.push_back(r);
			end else begin
				updates_seen++;
				for (int i = 0; i < slot_count; i++) begin
					if (slot_active[i]) begin
						elapsed = it.now_ticks - slot_start[i];
						need = NEED_W'(slot_period[i]) * NEED_W'(ticks_per_ms);
						if (NEED_W'(elapsed) >= need) begin
							r = '0;
							r.task_index = TIDX_W'(i);
							r.fired = 1'b1;
							due_results.push_back(r);
							fired_now++;
							if (slot_periodic[i])
								slot_start[i] = it.now_ticks;
							else
								slot_active[i] = 1'b0;
						end
					end
				end
				if (fired_now == 0) begin
					r = '0;
					r.last = 1'b1;
					due_results.push_back(r);
				end else begin
					r = due_results.pop_back();
					r.last = 1'b1;
					due_results.push_back(r);
				end
				fires_seen += fired_now;
			end
		endfunction

		function void check_result(timer_result_t got);
			timer_result_t want;
			if (due_results.size() == 0) begin
				$error("result beat with nothing expected: task_index %0d fired %0b last %0b",
					got.task_index, got.fired, got.last);
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			if (got.task_index !== want.task_index) begin
				$error("task_index: expected %0d, got %0d", want.task_index, got.task_index);
				mismatches++;
			end
			if (got.accepted !== want.accepted) begin
				$error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
				mismatches++;
			end
			if (got.fired !== want.fired) begin
				$error("fired: expected %0b, got %0b", want.fired, got.fired);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	itt_item_if   item_ch();
	itt_result_if result_ch();

	timer_slot_book    book;
	int unsigned       snd_idle_pct = 13;
	int unsigned       rcv_idle_pct = 65;
	bit                hold_req = 1'b0;
	int unsigned       cycle_count = 0;
	logic [TICK_W-1:0] wall;

	interval_task_timer_table uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			book.check_result({result_ch.task_index, result_ch.accepted,
				result_ch.fired, result_ch.last});
	end

	// The long hold-off lets the table back up and stall its input.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
			end
		end
	end

	task automatic send_item(timer_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.cmd       <= it.cmd;
		item_ch.now_ticks <= it.now_ticks;
		item_ch.period_ms <= it.period_ms;
		item_ch.periodic  <= it.periodic;
		do @(posedge clk); while (!item_ch.ready);
		book.note_item(it);
	endtask

	task automatic send_create(logic [TICK_W-1:0] now, logic [PERIOD_W-1:0] per, logic rep);
		timer_item_t it;
		it.cmd       = CMD_CREATE;
		it.now_ticks = now;
		it.period_ms = per;
		it.periodic  = rep;
		send_item(it);
	endtask

	task automatic send_update(logic [TICK_W-1:0] now);
		timer_item_t it;
		it.cmd       = CMD_UPDATE;
		it.now_ticks = now;
		it.period_ms = $urandom();
		it.periodic  = 1'($urandom_range(0, 1));
		send_item(it);
	endtask

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[PADDR_W-1:2] == REG_TICKS_PER_MS)
			book.ticks_per_ms = data[TPM_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (book.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [TICK_W-1:0] t0;
		logic [TPM_W-1:0]  tpm_val;
		int unsigned       step_max;
		book = new();
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		item_ch.valid     = 1'b0;
		item_ch.cmd       = CMD_CREATE;
		item_ch.now_ticks = '0;
		item_ch.period_ms = '0;
		item_ch.periodic  = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset tick rate. The start times sit just below
		// the wrap point, so later scans see both wrapped and huge elapsed counts.
		t0 = 32'hFFFF_FF00;
		send_update('0);
		send_create(t0, 32'd3, 1'b1);
		send_create(t0, 32'd0, 1'b0);
		send_create(t0 + 1, 32'hFFFF_FFFF, 1'b1);
		send_create(t0, 32'd10, 1'b1);
		send_create(t0 + 2, 32'd1, 1'b0);
		send_create(t0, 32'd50, 1'b1);
		send_create(t0, 32'd2, 1'b1);
		send_create(t0, 32'd200, 1'b1);
		send_create(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_create('0, '0, 1'b0);
		send_update(t0);
		send_update(t0 + 1);
		send_update(t0 + 3);
		send_update(t0 + 12);
		send_update(t0 + 300);
		send_update(t0 + 300);
		send_update(32'hFFFF_FFFF);
		send_update(t0 + 512);
		wall = t0 + 600;

		for (int phase = 0; phase < 6; phase++) begin
			wait_drained();
			case (phase / 2)
				0: begin
					snd_idle_pct = 13;
					rcv_idle_pct = 65;
				end
				1: begin
					snd_idle_pct = 65;
					rcv_idle_pct = 13;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			case (phase)
				0: tpm_val = TPM_W'($urandom_range(2, 1000));
				1: tpm_val = 16'hFFFF;
				2: tpm_val = '0;
				3: tpm_val = TPM_RESET;
				4: tpm_val = TPM_W'($urandom_range(1, 16'hFFFF));
				default: tpm_val = 16'd7;
			endcase
			if (phase == 3)
				apb_write({~REG_TICKS_PER_MS, 2'b00}, $urandom());
			apb_write({REG_TICKS_PER_MS, 2'b00}, {16'($urandom()), tpm_val});
			if (phase == 4)
				hold_req = 1'b1;
			step_max = 30 * ((tpm_val == 0) ? 1 : tpm_val);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 4) == 0) begin
					send_create($urandom(), $urandom(), 1'($urandom_range(0, 1)));
				end else begin
					if ($urandom_range(0, 9) == 0)
						wall = $urandom();
					else
						wall = wall + $urandom_range(0, step_max);
					send_update(wall);
				end
			end
		end
		@(negedge clk);
		item_ch.valid <= 1'b0;
		wait_drained();

		$display("Ran %0d items: %0d update scans and %0d refused creates over six tick rates,",
			book.items_seen, book.updates_seen, book.refusals_seen);
		$display("zero, one and 65535 among them; %0d slot firings came back in order.",
			book.fires_seen);
		if (book.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
